@@ design/pfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the pair force accumulator.
// No dependencies.
package pfa_pkg;

    localparam int MAX_OWN_DEF    = 64;
    localparam int MAX_GHOSTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_SQR = 1'b1;

    localparam logic [30:0] HORIZON_RST     = 31'd131072;
    localparam logic [30:0] HORIZON_SQR_RST = 31'd262144;

    typedef enum logic {
        KIND_OWN   = 1'b0,
        KIND_GHOST = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [7:0]         colour;
        logic               is_last;
    } t_item;

    typedef struct packed {
        logic [5:0]         particle_index;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               dropped;
        logic               last_force;
    } t_result;

endpackage

@@ design/pair_force_accumulator_core.sv @@
`timescale 1ns / 1ps
// Top level of the pair force accumulator: load stores, pair sequencer,
// shared multiplier, radix-2 reciprocal unit. Depends on pfa_pkg.
//
// Usage:
//  - Load channel: an item is taken at a clock edge with i_start high and
//    o_busy low. Own items and ghost items fill their stores in load order;
//    items beyond capacity are discarded and reported via dropped.
//  - The item flagged is_last is stored, then o_busy rises and the pair
//    sequencer runs. One result per own particle appears on o_res with
//    o_res_valid high for one cycle, in load order; last_force marks the
//    final one, after which o_busy falls and a new run can be loaded.
//  - Results cannot be held off; the receiver must take every strobe.
//  - Config channel: i_cfg_valid/o_cfg_ready, always ready; index 0 is the
//    per-axis horizon, index 1 the squared horizon. Write only while idle.
//  - Timing: one loaded item per cycle while idle. A pair culled per axis
//    skips to S_ACC after S_SQX, one culled by the squared test after S_SUM;
//    any other pair is set by the reciprocal, one quotient bit per cycle, and
//    the shared 32x32 multiplier. Pairs: n*(n-1)/2 own plus n*ghosts; each own
//    particle adds row setup (S_ROW, S_ROWW) and its result (S_EMIT).
//  - Reset (synchronous, active low) empties both stores, clears the
//    overflow flag and restores the register defaults. Store contents
//    need no clearing.
module pair_force_accumulator_core
    import pfa_pkg::*;
#(
    parameter int MAX_OWN    = MAX_OWN_DEF,
    parameter int MAX_GHOSTS = MAX_GHOSTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_item                i_in,
    output logic                 o_res_valid,
    output t_result              o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int OIW = (MAX_OWN > 1) ? $clog2(MAX_OWN) : 1;
    localparam int GIW = (MAX_GHOSTS > 1) ? $clog2(MAX_GHOSTS) : 1;
    localparam int OCW = $clog2(MAX_OWN + 1);
    localparam int GCW = $clog2(MAX_GHOSTS + 1);
    localparam int CW  = (OCW > GCW) ? OCW : GCW;
    localparam int DW  = $clog2(2 * FRAC_BITS + 1);

    localparam logic [31:0] HALF     = 32'(2 ** (FRAC_BITS - 1));
    localparam logic [31:0] QNEG     = 32'(0) - 32'(2 ** (FRAC_BITS - 2));
    localparam logic [31:0] THRESH   = 32'((46 * (2 ** FRAC_BITS)) / 100);
    localparam logic [DW-1:0] DTOP   = DW'(2 * FRAC_BITS);

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_ROW   = 19'h00002,
        S_ROWW  = 19'h00004,
        S_PAIR  = 19'h00008,
        S_PAIRW = 19'h00010,
        S_SQX   = 19'h00020,
        S_SQY   = 19'h00040,
        S_SUM   = 19'h00080,
        S_DIV   = 19'h00100,
        S_I4    = 19'h00200,
        S_I6    = 19'h00400,
        S_I8    = 19'h00800,
        S_TRM   = 19'h01000,
        S_SCL   = 19'h02000,
        S_FX    = 19'h04000,
        S_FY    = 19'h08000,
        S_FW    = 19'h10000,
        S_ACC   = 19'h20000,
        S_EMIT  = 19'h40000
    } t_state;

    // stores: {x, y, colour} and {force_x, force_y}
    logic [71:0] own_mem   [MAX_OWN];
    logic [71:0] ghost_mem [MAX_GHOSTS];
    logic [63:0] acc_mem   [MAX_OWN];

    t_state r_state, n_state;
    logic [OCW-1:0] r_own_cnt;
    logic [GCW-1:0] r_ghost_cnt;
    logic           r_ovf;
    logic [30:0]    r_horizon, r_horizon_sqr;
    logic [OCW-1:0] r_i;
    logic [CW-1:0]  r_j;
    logic           r_ghost_ph;

    logic [71:0] r_own_rd, r_ghost_rd;
    logic [63:0] r_acc_rd;
    logic [31:0] r_ax, r_ay;
    logic [7:0]  r_acol;
    logic [31:0] r_sumx, r_sumy;
    logic [31:0] r_dx, r_dy;
    logic        r_attract;
    logic [31:0] r_accjx, r_accjy;
    logic [31:0] r_prod, r_sq;
    logic [31:0] r_div, r_q, r_inv4, r_inv6, r_scale, r_fx, r_fy;
    logic [32:0] r_rem;
    logic [DW-1:0] r_dstep;

    logic        accept, own_ok, ghost_ok;
    logic [OCW-1:0] own_cnt_nx;
    logic [31:0] ma, mb, fm, dist_sq, mag_dx, mag_dy, bx, by;
    logic [7:0]  bcol;
    logic signed [63:0] prod;
    logic [32:0] trial;
    logic [CW-1:0] j_inc;
    logic [CW-1:0] own_cnt_w, ghost_cnt_w;

    assign accept      = i_start && (r_state == S_IDLE);
    assign own_ok      = r_own_cnt < OCW'(MAX_OWN);
    assign ghost_ok    = r_ghost_cnt < GCW'(MAX_GHOSTS);
    assign own_cnt_nx  = (i_in.kind == KIND_OWN && own_ok) ? r_own_cnt + 1'b1 : r_own_cnt;
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign own_cnt_w   = CW'(r_own_cnt);
    assign ghost_cnt_w = CW'(r_ghost_cnt);
    assign j_inc       = r_j + 1'b1;

    // shared multiplier, Q-format product with floor shift
    always_comb begin
        unique case (r_state)
            S_SQX:   begin ma = r_dx;   mb = r_dx;    end
            S_SQY:   begin ma = r_dy;   mb = r_dy;    end
            S_I4:    begin ma = r_q;    mb = r_q;     end
            S_I6:    begin ma = r_prod; mb = r_q;     end
            S_I8:    begin ma = r_inv4; mb = r_inv4;  end
            S_TRM:   begin ma = r_attract ? HALF : QNEG; mb = r_prod; end
            S_FX:    begin ma = r_dx;   mb = r_scale; end
            S_FY:    begin ma = r_dy;   mb = r_scale; end
            default: begin ma = '0;     mb = '0;      end
        endcase
    end
    assign prod = $signed(ma) * $signed(mb);
    assign fm   = prod[FRAC_BITS+31:FRAC_BITS];

    assign mag_dx  = r_dx[31] ? 32'(0) - r_dx : r_dx;
    assign mag_dy  = r_dy[31] ? 32'(0) - r_dy : r_dy;
    assign dist_sq = r_sq + r_prod;
    assign trial   = {r_rem[31:0], (r_dstep == DTOP)};

    assign bx   = r_ghost_ph ? r_ghost_rd[71:40] : r_own_rd[71:40];
    assign by   = r_ghost_ph ? r_ghost_rd[39:8]  : r_own_rd[39:8];
    assign bcol = r_ghost_ph ? r_ghost_rd[7:0]   : r_own_rd[7:0];

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && i_in.kind == KIND_OWN && own_ok) begin
            own_mem[r_own_cnt[OIW-1:0]] <= {i_in.pos_x, i_in.pos_y, i_in.colour};
        end
        if (accept && i_in.kind == KIND_GHOST && ghost_ok) begin
            ghost_mem[r_ghost_cnt[GIW-1:0]] <= {i_in.pos_x, i_in.pos_y, i_in.colour};
        end
        if (r_state == S_ACC && !r_ghost_ph) begin
            acc_mem[r_j[OIW-1:0]] <= {r_accjx - r_fx, r_accjy - r_fy};
        end
        r_own_rd   <= own_mem[(r_state == S_ROW) ? r_i[OIW-1:0] : r_j[OIW-1:0]];
        r_ghost_rd <= ghost_mem[r_j[GIW-1:0]];
        r_acc_rd   <= acc_mem[(r_state == S_ROW) ? r_i[OIW-1:0] : r_j[OIW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_in.is_last && own_cnt_nx != '0) n_state = S_ROW;
            S_ROW:   n_state = S_ROWW;
            S_ROWW:  n_state = (OCW'(r_i + 1'b1) < r_own_cnt || r_ghost_cnt != '0)
                               ? S_PAIR : S_EMIT;
            S_PAIR:  n_state = S_PAIRW;
            S_PAIRW: n_state = S_SQX;
            S_SQX:   n_state = (mag_dx > {1'b0, r_horizon} || mag_dy > {1'b0, r_horizon})
                               ? S_ACC : S_SQY;
            S_SQY:   n_state = S_SUM;
            S_SUM:   n_state = ($signed(dist_sq) > $signed({1'b0, r_horizon_sqr}))
                               ? S_ACC : S_DIV;
            S_DIV:   if (r_dstep == '0) n_state = S_I4;
            S_I4:    n_state = S_I6;
            S_I6:    n_state = S_I8;
            S_I8:    n_state = S_TRM;
            S_TRM:   n_state = S_SCL;
            S_SCL:   n_state = S_FX;
            S_FX:    n_state = S_FY;
            S_FY:    n_state = S_FW;
            S_FW:    n_state = S_ACC;
            S_ACC: begin
                if (r_ghost_ph) begin
                    n_state = (j_inc == ghost_cnt_w) ? S_EMIT : S_PAIR;
                end else begin
                    n_state = (j_inc == own_cnt_w && r_ghost_cnt == '0) ? S_EMIT : S_PAIR;
                end
            end
            S_EMIT:  n_state = (OCW'(r_i + 1'b1) == r_own_cnt) ? S_IDLE : S_ROW;
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_own_cnt     <= '0;
            r_ghost_cnt   <= '0;
            r_ovf         <= 1'b0;
            r_i           <= '0;
            r_j           <= '0;
            r_ghost_ph    <= 1'b0;
            r_horizon     <= HORIZON_RST;
            r_horizon_sqr <= HORIZON_SQR_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HORIZON:     r_horizon     <= i_cfg_data;
                    CFG_HORIZON_SQR: r_horizon_sqr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_in.kind == KIND_OWN) begin
                    if (own_ok) r_own_cnt <= r_own_cnt + 1'b1;
                    else        r_ovf     <= 1'b1;
                end else begin
                    if (ghost_ok) r_ghost_cnt <= r_ghost_cnt + 1'b1;
                    else          r_ovf       <= 1'b1;
                end
                if (i_in.is_last && own_cnt_nx == '0) begin
                    // empty run: nothing to report
                    r_own_cnt   <= '0;
                    r_ghost_cnt <= '0;
                    r_ovf       <= 1'b0;
                end
                r_i <= '0;
            end
            if (r_state == S_ROWW) begin
                r_ghost_ph <= !(OCW'(r_i + 1'b1) < r_own_cnt);
                r_j        <= (OCW'(r_i + 1'b1) < r_own_cnt) ? CW'(r_i + 1'b1) : '0;
            end
            if (r_state == S_ACC) begin
                if (!r_ghost_ph && j_inc == own_cnt_w) begin
                    r_ghost_ph <= 1'b1;
                    r_j        <= '0;
                end else begin
                    r_j <= j_inc;
                end
            end
            if (r_state == S_EMIT) begin
                r_i <= r_i + 1'b1;
                if (OCW'(r_i + 1'b1) == r_own_cnt) begin
                    r_own_cnt   <= '0;
                    r_ghost_cnt <= '0;
                    r_ovf       <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= fm;
        unique case (r_state)
            S_ROWW: begin
                r_ax   <= r_own_rd[71:40];
                r_ay   <= r_own_rd[39:8];
                r_acol <= r_own_rd[7:0];
                r_sumx <= (r_i == '0) ? 32'd0 : r_acc_rd[63:32];
                r_sumy <= (r_i == '0) ? 32'd0 : r_acc_rd[31:0];
            end
            S_PAIRW: begin
                r_dx      <= bx - r_ax;
                r_dy      <= by - r_ay;
                r_attract <= (bcol == r_acol);
                r_accjx   <= (r_i == '0) ? 32'd0 : r_acc_rd[63:32];
                r_accjy   <= (r_i == '0) ? 32'd0 : r_acc_rd[31:0];
            end
            S_SQX: begin
                r_fx <= '0;
                r_fy <= '0;
            end
            S_SQY: r_sq <= r_prod;
            S_SUM: begin
                r_div   <= ($signed(dist_sq) < $signed(THRESH)) ? THRESH : dist_sq;
                r_rem   <= '0;
                r_q     <= '0;
                r_dstep <= DTOP;
            end
            S_DIV: begin
                // restoring division of 2^(2F) by the clamped distance
                if (trial >= {1'b0, r_div}) begin
                    r_rem <= trial - {1'b0, r_div};
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_dstep <= r_dstep - 1'b1;
            end
            S_I6:  r_inv4 <= r_prod;
            S_I8:  r_inv6 <= r_prod;
            S_SCL: r_scale <= r_attract ? r_inv6 - r_prod : r_prod;
            S_FY:  r_fx <= r_prod;
            S_FW:  r_fy <= r_prod;
            S_ACC: begin
                r_sumx <= r_sumx + r_fx;
                r_sumy <= r_sumy + r_fy;
            end
            default: ;
        endcase
    end

    assign o_res_valid          = (r_state == S_EMIT);
    assign o_res.particle_index = 6'(r_i);
    assign o_res.force_x        = r_sumx;
    assign o_res.force_y        = r_sumy;
    assign o_res.dropped        = r_ovf;
    assign o_res.last_force     = (OCW'(r_i + 1'b1) == r_own_cnt);

endmodule

@@ design/pfa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the pair force accumulator, bound to the top level.
// Depends on pfa_pkg.
module pfa_checker
    import pfa_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input t_item   i_in,
    input logic    o_res_valid,
    input t_result o_res
);

    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_busy) else $error("result while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_force |=> !o_busy) else $error("busy after last");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_force |=> o_busy) else $error("run ended early");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && !i_in.is_last |=> !o_busy) else $error("busy mid load");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy && !o_res_valid) else $error("busy after reset");

endmodule

bind pair_force_accumulator_core pfa_checker u_pfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_in        (i_in),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
